// ===== src/tnz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnz_pkg: shared types and constants for the tau-NAF converter
// Field widths, digit codes, channel payload structs and the control
// structs that pass between the sequencer and its helper units.
// ----------------------------------------------------------------------------
package tnz_pkg;

    localparam int INPUT_WIDTH = 16;
    localparam int MAX_DIGITS  = 40;
    // The remainder grows by at most two bits over the conversion.
    localparam int REM_W       = INPUT_WIDTH + 2;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 6;
    localparam int TALLY_W     = 16;
    localparam int DIGIT_W     = 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [IDX_W:0]     MAX_DIGITS_W = (IDX_W + 1)'(MAX_DIGITS);

    localparam logic signed [DIGIT_W-1:0] DIGIT_ZERO = 2'sb00;
    localparam logic signed [DIGIT_W-1:0] DIGIT_POS  = 2'sb01;
    localparam logic signed [DIGIT_W-1:0] DIGIT_NEG  = 2'sb11;

    typedef struct packed {
        logic signed [INPUT_WIDTH-1:0] real_part;
        logic signed [INPUT_WIDTH-1:0] tau_part;
    } in_t;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic [IDX_W-1:0]          digit_index;
        logic                      last;
        logic                      empty_res;
        logic [CNT_W-1:0]          zero_total;
        logic                      fault_detected;
        logic [TALLY_W-1:0]        fault_tally;
    } out_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // One remainder update: the digit taken off and the remainder divided by tau.
    typedef struct packed {
        logic signed [DIGIT_W-1:0] dig;
        logic                      dig_zero;
        logic signed [REM_W-1:0]   real_next;
        logic signed [REM_W-1:0]   tau_next;
        logic                      rem_done;
    } step_res_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic dig_zero;
        logic fin;
    } chk_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]   gen_next;
        logic               fault;
        logic [TALLY_W-1:0] tally_cur;
        logic [TALLY_W-1:0] tally_upd;
    } chk_stat_t;

endpackage

// ===== src/tau_naf_with_zero_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tau_naf_with_zero_check_unit: tau-NAF converter with zero-count check
// Converts r0 + r1*tau (mu = 1) into tau-NAF digits, least significant first,
// one result beat per digit, with a coherency check on the zero digits.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake           Payload
//  s_        in    s_valid / s_ready   in_t  : real_part, tau_part
//  m_        out   m_valid / m_ready   out_t : one digit per beat
//
//  An input beat is accepted in ST_IDLE; then the step unit makes one digit
//  per cycle while the output register is free, up to MAX_DIGITS digits per
//  item. A zero input gives one empty beat.
//  s_ready is high only between items; the next item may be taken while the
//  final result beat still waits in the output register.
//  A stall on m_ready holds the step unit until the output register frees.
//  Reset is synchronous, active low, and clears control state and the tally.
// ----------------------------------------------------------------------------
module tau_naf_with_zero_check_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tnz_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tnz_pkg::out_t m_data
);
    import tnz_pkg::*;

    state_t                  state_reg, state_next;
    logic signed [REM_W-1:0] rem_real_reg, rem_real_next;
    logic signed [REM_W-1:0] rem_tau_reg,  rem_tau_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic                    m_valid_reg, m_valid_next;
    out_t                    out_reg, out_next;

    step_res_t  step_res;
    chk_ctrl_t  chk_ctrl;
    chk_stat_t  chk_stat;

    logic       in_beat;
    logic       out_free;
    logic       rem_zero;
    logic       fin;

    tnz_step u_step (
        .rem_real (rem_real_reg),
        .rem_tau  (rem_tau_reg),
        .res      (step_res)
    );

    tnz_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (chk_ctrl),
        .stat    (chk_stat)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        in_beat  = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        rem_zero = (rem_real_reg == '0) && (rem_tau_reg == '0);
        fin      = step_res.rem_done || (({1'b0, pos_reg} + 1'b1) >= MAX_DIGITS_W);

        state_next    = state_reg;
        rem_real_next = rem_real_reg;
        rem_tau_next  = rem_tau_reg;
        pos_next      = pos_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;

        chk_ctrl.clear    = 1'b0;
        chk_ctrl.step     = 1'b0;
        chk_ctrl.dig_zero = step_res.dig_zero;
        chk_ctrl.fin      = fin;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    rem_real_next  = REM_W'(s_data.real_part);
                    rem_tau_next   = REM_W'(s_data.tau_part);
                    pos_next       = '0;
                    chk_ctrl.clear = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (rem_zero) begin
                        // Only reachable on the first step: the zero input.
                        out_next.digit          = DIGIT_ZERO;
                        out_next.digit_index    = '0;
                        out_next.last           = 1'b1;
                        out_next.empty_res      = 1'b1;
                        out_next.zero_total     = '0;
                        out_next.fault_detected = 1'b0;
                        out_next.fault_tally    = chk_stat.tally_cur;
                        state_next              = ST_IDLE;
                    end else begin
                        chk_ctrl.step           = 1'b1;
                        out_next.digit          = step_res.dig;
                        out_next.digit_index    = pos_reg;
                        out_next.last           = fin;
                        out_next.empty_res      = 1'b0;
                        out_next.zero_total     = fin ? chk_stat.gen_next : '0;
                        out_next.fault_detected = fin && chk_stat.fault;
                        out_next.fault_tally    = fin ? chk_stat.tally_upd
                                                      : chk_stat.tally_cur;
                        rem_real_next           = step_res.real_next;
                        rem_tau_next            = step_res.tau_next;
                        pos_next                = pos_reg + 1'b1;
                        if (fin) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_real_reg <= rem_real_next;
        rem_tau_reg  <= rem_tau_next;
        pos_reg      <= pos_next;
        out_reg      <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_in_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_RUN)
        else $error("accepted input did not start a conversion");

    a_mid_beat_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> state_reg == ST_RUN)
        else $error("conversion ended without a last beat");

    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_res |->
            m_data.last && m_data.digit == DIGIT_ZERO && m_data.digit_index == '0)
        else $error("empty result beat is malformed");

    a_totals_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.zero_total == '0 && !m_data.fault_detected)
        else $error("totals reported before the last beat");

    a_counts_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> !m_data.fault_detected)
        else $error("zero counts disagree");
`endif

endmodule

// ===== src/tnz_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnz_step: tau-NAF digit and remainder update unit
// Picks the next digit from the remainder, removes it and divides the
// remainder by tau (tau^2 = tau - 2). Used once per digit by the sequencer.
// ----------------------------------------------------------------------------
module tnz_step (
    input  logic signed [tnz_pkg::REM_W-1:0] rem_real,
    input  logic signed [tnz_pkg::REM_W-1:0] rem_tau,
    output tnz_pkg::step_res_t               res
);
    import tnz_pkg::*;

    logic signed [REM_W-1:0] even_real;
    logic signed [REM_W-1:0] half_real;
    logic signed [DIGIT_W-1:0] dig;

    // For odd r0 the value (r0 - 2*r1) mod 4 is 1 or 3, set by r0[1] xor r1[0].
    always_comb begin
        if (rem_real[0]) begin
            dig = (rem_real[1] ^ rem_tau[0]) ? DIGIT_NEG : DIGIT_POS;
        end else begin
            dig = DIGIT_ZERO;
        end
        even_real = rem_real - REM_W'(dig);
        half_real = even_real >>> 1;
        res.dig       = dig;
        res.dig_zero  = ~rem_real[0];
        res.real_next = rem_tau + half_real;
        res.tau_next  = -half_real;
        res.rem_done  = (res.real_next == '0) && (res.tau_next == '0);
    end

endmodule

// ===== src/tnz_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnz_check: zero-digit coherency check and fault tally
// Keeps the generated and the emitted zero counts, compares them on the
// final digit and keeps a saturating tally of mismatches.
// ----------------------------------------------------------------------------
module tnz_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  tnz_pkg::chk_ctrl_t  ctrl,
    output tnz_pkg::chk_stat_t  stat
);
    import tnz_pkg::*;

    logic [CNT_W-1:0]   gen_reg,   gen_next;
    logic [CNT_W-1:0]   seen_reg,  seen_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [TALLY_W-1:0] tally_upd;
    logic               fault;

    always_comb begin
        gen_next  = gen_reg + CNT_W'(ctrl.dig_zero);
        seen_next = seen_reg + CNT_W'(ctrl.dig_zero);
        fault     = (gen_next != seen_next);
        tally_upd = (fault && (tally_reg != TALLY_MAX)) ? tally_reg + 1'b1 : tally_reg;
        tally_next = (ctrl.step && ctrl.fin) ? tally_upd : tally_reg;
        stat.gen_next  = gen_next;
        stat.fault     = fault;
        stat.tally_cur = tally_reg;
        stat.tally_upd = tally_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg   <= '0;
            seen_reg  <= '0;
            tally_reg <= '0;
        end else begin
            tally_reg <= tally_next;
            if (ctrl.clear) begin
                gen_reg  <= '0;
                seen_reg <= '0;
            end else if (ctrl.step) begin
                gen_reg  <= gen_next;
                seen_reg <= seen_next;
            end
        end
    end

endmodule
